>>> rtl/core/csvq_pkg.sv
package csvq_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] QUOTE_RESET  = 8'd34;
  localparam logic [7:0] ESCAPE_RESET = 8'd96;

  localparam logic REG_QUOTE  = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  localparam int PUSH_MAX   = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0]              count;
    item_t [PUSH_MAX-1:0]    items;
  } push_t;

  typedef struct packed {
    logic [7:0] win0;
    logic [7:0] win1;
    logic [1:0] held;
    logic       skip;
    logic       in_string;
  } win_state_t;

endpackage

>>> rtl/core/csvq_decide.sv
module csvq_decide
  import csvq_pkg::*;
(
  input  win_state_t st,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] quote_char,
  input  logic [7:0] escape_char,
  output win_state_t st_next,
  output push_t      push
);

  logic [7:0] d0;
  logic [7:0] b1_new;
  logic       skip_new;
  logic       ins_new;
  logic       q0;
  logic       q1;
  logic       q2;
  logic       full;

  assign q0   = (st.win0 == quote_char);
  assign q1   = (st.win1 == quote_char);
  assign q2   = (data_byte == quote_char);
  assign full = st.held[1];

  always_comb begin
    d0       = st.win0;
    b1_new   = st.win1;
    skip_new = st.skip;
    ins_new  = st.in_string;
    if (st.skip) begin
      skip_new = 1'b0;
    end else if (st.win0 == NEWLINE_BYTE) begin
      ins_new = 1'b0;
    end else if (q0 && q1) begin
      if (st.in_string) begin
        d0 = escape_char;
      end else if (q2) begin
        b1_new = escape_char;
      end
      skip_new = 1'b1;
    end else if (q0) begin
      ins_new = !st.in_string;
    end
  end

  always_comb begin
    st_next = st;
    push    = '0;
    if (!last_byte) begin
      if (!full) begin
        if (st.held[0]) begin
          st_next.win1 = data_byte;
        end else begin
          st_next.win0 = data_byte;
        end
        st_next.held = st.held + 2'd1;
      end else begin
        push.count          = 2'd1;
        push.items[0]       = '{data: d0, last: 1'b0};
        st_next.win0        = b1_new;
        st_next.win1        = data_byte;
        st_next.held        = 2'd2;
        st_next.skip        = skip_new;
        st_next.in_string   = ins_new;
      end
    end else begin
      st_next = '0;
      if (full) begin
        push.count    = 2'd3;
        push.items[0] = '{data: d0, last: 1'b0};
        push.items[1] = '{data: b1_new, last: 1'b0};
        push.items[2] = '{data: data_byte, last: 1'b1};
      end else if (st.held[0]) begin
        push.count    = 2'd2;
        push.items[0] = '{data: st.win0, last: 1'b0};
        push.items[1] = '{data: data_byte, last: 1'b1};
      end else begin
        push.count    = 2'd1;
        push.items[0] = '{data: data_byte, last: 1'b1};
      end
    end
  end

endmodule

>>> rtl/core/csvq_fifo.sv
module csvq_fifo
  import csvq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];
  assign room      = (count <= CNT_W'(FIFO_DEPTH - PUSH_MAX));

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (2'(k) < push.count) begin
        mem[wr_ptr + PTR_W'(k)] <= push.items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

>>> rtl/core/csv_quote_escape_rewriter.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    data_byte, last_byte
// out       out_valid / out_ready  out_byte, out_last
// cfg       cfg_we                 cfg_index, cfg_data
//
// One byte accepted per cycle while in_ready is high; a transfer writes its results
// into a four-entry output queue, up to three for a last byte. The queue drains one
// per cycle while out_ready is high; in_ready is low while fewer than three slots are free.
// rst (synchronous) clears the window, flags and queue and loads the register defaults.
// An output stall fills the queue and then holds off input.
module csv_quote_escape_rewriter
  import csvq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] quote_char;
  logic [7:0] escape_char;
  win_state_t st;
  win_state_t st_next;
  push_t      push_raw;
  push_t      push;
  item_t      out_item;
  logic       accept;

  assign accept = in_valid && in_ready;
  assign push   = accept ? push_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char  <= QUOTE_RESET;
      escape_char <= ESCAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUOTE:  quote_char  <= cfg_data;
        REG_ESCAPE: escape_char <= cfg_data;
        default:    quote_char  <= quote_char;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  csvq_decide u_decide (
    .st          (st),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .quote_char  (quote_char),
    .escape_char (escape_char),
    .st_next     (st_next),
    .push        (push_raw)
  );

  csvq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_byte = out_item.data;
  assign out_last = out_item.last;

`ifndef SYNTHESIS
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> st.held == 2'd0 && !st.in_string && !st.skip)
    else $error("state not cleared after last byte");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    st.held != 2'd3)
    else $error("held count out of range");

  a_skip_full: assert property (@(posedge clk) disable iff (rst)
    st.skip |-> st.held == 2'd2)
    else $error("skip pending without full window");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && (last_byte || st.held[1]) |=> out_valid)
    else $error("missing result after transfer");
`endif

endmodule

>>> tb/csvq_checker.sv
`timescale 1ns / 100ps

module csvq_checker
  import csvq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pending
);

  item_t      owed_q[$];
  logic [7:0] quote_sym;
  logic [7:0] escape_sym;
  logic [7:0] win [2];
  logic [1:0] held;
  logic       skip_pend;
  logic       quoted;
  int         bad_n;

  initial begin
    bad_n      = 0;
    mismatches = 0;
    pending    = 0;
  end

  function automatic void clear_window();
    win[0]    = 8'h00;
    win[1]    = 8'h00;
    held      = 2'd0;
    skip_pend = 1'b0;
    quoted    = 1'b0;
  endfunction

  function automatic logic [7:0] judge_oldest(input logic [7:0] newest);
    logic [7:0] head;
    head = win[0];
    if (skip_pend) begin
      skip_pend = 1'b0;
    end else if (head == NEWLINE_BYTE) begin
      quoted = 1'b0;
    end else if (head == quote_sym && win[1] == quote_sym) begin
      if (quoted) head = escape_sym;
      else if (newest == quote_sym) win[1] = escape_sym;
      skip_pend = 1'b1;
    end else if (head == quote_sym) begin
      quoted = !quoted;
    end
    return head;
  endfunction

  task automatic owe(input logic [7:0] b, input logic l);
    item_t r;
    r.data = b;
    r.last = l;
    owed_q.push_back(r);
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic l);
    logic [1:0] n;
    n = (held > 2'd2) ? 2'd2 : held;
    if (!l) begin
      if (n < 2'd2) begin
        win[n[0]] = b;
        held      = n + 2'd1;
      end else begin
        owe(judge_oldest(b), 1'b0);
        win[0] = win[1];
        win[1] = b;
        held   = 2'd2;
      end
    end else begin
      if (n == 2'd2) begin
        owe(judge_oldest(b), 1'b0);
        owe(win[1], 1'b0);
      end else if (n == 2'd1) begin
        owe(win[0], 1'b0);
      end
      owe(b, 1'b1);
      clear_window();
    end
  endtask

  task automatic flag(input string what, input item_t want);
    bad_n++;
    if (bad_n <= 10)
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b",
               $realtime, what, want.data, want.last, out_byte, out_last);
  endtask

  always @(posedge clk) begin
    item_t head_r;
    if (rst) begin
      owed_q.delete();
      quote_sym  = QUOTE_RESET;
      escape_sym = ESCAPE_RESET;
      clear_window();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_QUOTE) quote_sym = cfg_data;
        else escape_sym = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          head_r = '0;
          flag("unexpected transfer", head_r);
        end else begin
          head_r = owed_q.pop_front();
          if (head_r.data !== out_byte || head_r.last !== out_last)
            flag("wrong output", head_r);
        end
      end
      if (in_valid && in_ready) rewrite_byte(data_byte, last_byte);
    end
    pending    <= owed_q.size();
    mismatches <= bad_n;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import csvq_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_QUOTE;
  logic [7:0] cfg_data = 8'h00;
  int         fail_n;
  int         pending;

  logic [7:0] quote_cur = QUOTE_RESET;
  logic [7:0] escape_cur = ESCAPE_RESET;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  int         rx_hold_len = 0;

  csv_quote_escape_rewriter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  csvq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_n),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hold off on request, otherwise stall for a random gap before each transfer unless rx_calm
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      gap = rx_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] q, input logic [7:0] e);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUOTE;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= REG_ESCAPE;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we     <= 1'b0;
    quote_cur  = q;
    escape_cur = e;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input bit noisy);
    int r;
    r = $urandom_range(0, 99);
    if (noisy || r >= 55) return 8'($urandom_range(0, 255));
    if (r < 40) return quote_cur;
    if (r < 50) return NEWLINE_BYTE;
    return escape_cur;
  endfunction

  task automatic random_streams(input int count);
    int sent;
    int len;
    bit noisy;
    sent = 0;
    while (sent < count) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      noisy   = ($urandom_range(0, 4) == 0);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_byte(pick_byte(noisy), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    logic [7:0] q;
    logic [7:0] a;
    q = QUOTE_RESET;
    a = 8'h61;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b1);
    send_byte(q, 1'b0); send_byte(q, 1'b0); send_byte(q, 1'b0); send_byte(q, 1'b1);
    send_byte(q, 1'b0); send_byte(a, 1'b0); send_byte(q, 1'b0);
    send_byte(q, 1'b0); send_byte(q, 1'b0); send_byte(8'h7F, 1'b1);
    send_byte(q, 1'b0); send_byte(NEWLINE_BYTE, 1'b0); send_byte(q, 1'b0);
    send_byte(q, 1'b0); send_byte(8'h7A, 1'b1);
    send_byte(q, 1'b0); send_byte(a, 1'b0); send_byte(q, 1'b0);
    send_byte(q, 1'b0); send_byte(8'h64, 1'b1);

    random_streams(20);
    set_regs(NEWLINE_BYTE, 8'h00);
    random_streams(20);
    set_regs(8'h00, 8'hFF);
    random_streams(20);
    set_regs(8'hFF, 8'hFF);
    random_streams(20);
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_streams(20);
    set_regs(QUOTE_RESET, ESCAPE_RESET);

    // stall the output long enough to back up the queue and hold off input
    tx_calm     = 1'b1;
    rx_hold_len = 60;
    for (int i = 0; i < 20; i++) send_byte(pick_byte(1'b0), i == 19);
    tx_calm = 1'b0;
    settle();
    random_streams(10);

    settle();
    repeat (10) @(posedge clk);
    if (fail_n == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/csvq_pkg.sv
rtl/core/csvq_decide.sv
rtl/core/csvq_fifo.sv
rtl/core/csv_quote_escape_rewriter.sv
tb/csvq_checker.sv
tb/testbench.sv
